FILE: hw/rtl/mh3_pkg.sv
// ----------------------------------------------------------------------------
// mh3_pkg: shared types and constants
// Hash constants, controller state codes and the control/status groups
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mh3_pkg;

  localparam logic [31:0] C1 = 32'hcc9e2d51;
  localparam logic [31:0] C2 = 32'h1b873593;
  localparam logic [31:0] MIX_ADD = 32'he6546b64;
  localparam logic [31:0] F1 = 32'h85ebca6b;
  localparam logic [31:0] F2 = 32'hc2b2ae35;

  localparam int unsigned CFG_AW = 2;
  localparam logic [CFG_AW-1:0] REG_SEED = 2'd0;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SCR1 = 8'b0000_0010,
    ST_SCR2 = 8'b0000_0100,
    ST_MIX  = 8'b0000_1000,
    ST_FIN1 = 8'b0001_0000,
    ST_FIN2 = 8'b0010_0000,
    ST_FIN3 = 8'b0100_0000,
    ST_FIN4 = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic ld;
    logic scr1;
    logic scr2;
    logic mix;
    logic fin1;
    logic fin2;
    logic fin3;
    logic fin4;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_stall;
  } sts_t;

endpackage

FILE: hw/rtl/mh3_ctrl.sv
// ----------------------------------------------------------------------------
// mh3_ctrl: sequencing controller
// Steps one word through scramble and mix, then runs the finalizer on the
// last word of a message.
// ----------------------------------------------------------------------------
module mh3_ctrl
  import mh3_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.ld = 1'b1;
          state_nxt = ST_SCR1;
        end
      end
      ST_SCR1: begin
        cmd.scr1 = 1'b1;
        state_nxt = ST_SCR2;
      end
      ST_SCR2: begin
        cmd.scr2 = 1'b1;
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        cmd.mix = 1'b1;
        state_nxt = sts.last ? ST_FIN1 : ST_IDLE;
      end
      ST_FIN1: begin
        cmd.fin1 = 1'b1;
        state_nxt = ST_FIN2;
      end
      ST_FIN2: begin
        cmd.fin2 = 1'b1;
        state_nxt = ST_FIN3;
      end
      ST_FIN3: begin
        cmd.fin3 = 1'b1;
        state_nxt = ST_FIN4;
      end
      ST_FIN4: begin
        // hold until the output register is free
        if (!sts.out_stall) begin
          cmd.fin4 = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/mh3_dp.sv
// ----------------------------------------------------------------------------
// mh3_dp: hash datapath
// Running hash, byte count, block scramble, finalizer and output register.
// ----------------------------------------------------------------------------
module mh3_dp
  import mh3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic [31:0] in_word,
  input  logic [2:0]  in_vb,
  input  logic        in_last,
  input  logic [31:0] seed,
  input  logic        out_tready,
  output logic        out_tvalid,
  output logic [31:0] out_hash,
  output sts_t        sts
);

  logic [31:0] h_r, total_r, k_r, f_r, out_hash_r;
  logic        start_r, full_r, last_r, out_valid_r;
  logic [1:0]  vb_r;

  logic [31:0] mask, p1, p2, pf1, pf2, hx, hrot, fx, f3x;

  always_comb begin
    case (in_vb)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
    if (!in_last) begin
      mask = 32'hffff_ffff;
    end
  end

  assign p1   = k_r * C1;
  assign p2   = k_r * C2;
  assign hx   = h_r ^ k_r;
  assign hrot = {hx[18:0], hx[31:19]};
  assign fx   = h_r ^ total_r;
  assign pf1  = f_r * F1;
  assign f3x  = f_r ^ (f_r >> 13);
  assign pf2  = f3x * F2;

  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      k_r    <= in_word & mask;
      full_r <= !in_last || (in_vb >= 3'd4);
      vb_r   <= in_vb[1:0];
      last_r <= in_last;
      if (start_r) begin
        h_r     <= seed;
        total_r <= '0;
      end
    end
    if (cmd.scr1) begin
      k_r <= {p1[16:0], p1[31:17]};
    end
    if (cmd.scr2) begin
      k_r <= p2;
    end
    if (cmd.mix) begin
      if (full_r) begin
        h_r     <= (hrot << 2) + hrot + MIX_ADD;
        total_r <= total_r + 32'd4;
      end else begin
        h_r     <= hx;
        total_r <= total_r + {30'd0, vb_r};
      end
    end
    if (cmd.fin1) begin
      f_r <= fx ^ (fx >> 16);
    end
    if (cmd.fin2) begin
      f_r <= pf1;
    end
    if (cmd.fin3) begin
      f_r <= pf2;
    end
    if (cmd.fin4) begin
      out_hash_r <= f_r ^ (f_r >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ld) begin
        start_r <= 1'b0;
      end else if (cmd.mix) begin
        start_r <= last_r;
      end
      if (cmd.fin4) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_hash      = out_hash_r;
  assign sts.last      = last_r;
  assign sts.out_stall = out_valid_r && !out_tready;

endmodule

FILE: hw/rtl/murmur3_hash32_stream.sv
// ----------------------------------------------------------------------------
// murmur3_hash32_stream: streaming MurmurHash3 x86_32
// Hashes a byte message arriving as little-endian words; seed via APB.
// ----------------------------------------------------------------------------
// Each word steps through accept, two scramble multiplies and hash update,
// with both 32x32 multiplies of the k scramble registered; no new word is
// taken until it is through. A last word adds the finalizer steps (two more
// multiplies) before the hash is loaded into the output register. The output
// register lets the next message's words be taken while a hash waits; the
// finalizer holds only if a second hash is ready before the first is taken.
module murmur3_hash32_stream
  import mh3_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // [31:0] data_word
  input  logic [2:0]        in_tuser,   // [2:0] valid_bytes
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // [31:0] hash
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [31:0] seed_r;
  cmd_t        cmd;
  sts_t        sts;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_SEED) ? seed_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_paddr == REG_SEED) begin
      seed_r <= cfg_pwdata;
    end
  end

  mh3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mh3_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_word    (in_tdata),
    .in_vb      (in_tuser),
    .in_last    (in_tlast),
    .seed       (seed_r),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_hash   (out_tdata),
    .sts        (sts)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again while a word is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !cmd.fin4)
    else $error("pending hash overwritten");

  a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin4 |=> out_tvalid)
    else $error("finalized hash not presented");

  a_accept_is_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) == cmd.ld)
    else $error("word accept and datapath load disagree");

endmodule
